// File: design/vn_pkg.sv
// Shared constants for the vector normalizer.
// Used by vn_lane and vector_normalize; no dependencies.
`default_nettype none
package vn_pkg;
  localparam int CW        = 16;            // component width
  localparam int NC        = 4;             // component count
  localparam int SQ_W      = 2 * CW;        // square of a magnitude
  localparam int SUM_W     = SQ_W + 2;      // sum of NC squares
  localparam int FRAC      = 30;            // Q1.15 squared
  localparam int Q_W       = FRAC + 1;      // quotient sq * 2^FRAC / sum
  localparam int DIV_STEPS = Q_W;
  localparam int RT_W      = 16;            // root width
  localparam int SQRT_STEPS = RT_W;
  localparam int SR_W      = RT_W + 2;      // root remainder
  localparam int LANE_LAT  = DIV_STEPS + SQRT_STEPS;
  localparam int NST       = 3 + LANE_LAT + 1;
endpackage
`default_nettype wire

// File: design/vn_lane.sv
// One component lane: restoring divide then digit-by-digit square root,
// one bit per pipeline stage. Depends on vn_pkg.
`default_nettype none
module vn_lane import vn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SQ_W-1:0]  sq,
  input  wire logic [SUM_W-1:0] sum,
  output logic      [RT_W-1:0]  root
);
  logic [SUM_W-1:0] dr [DIV_STEPS];
  logic [SUM_W-1:0] ds [DIV_STEPS];
  logic [Q_W-1:0]   dq [DIV_STEPS];
  logic [SR_W-1:0]  srem  [SQRT_STEPS];
  logic [RT_W-1:0]  sroot [SQRT_STEPS];
  logic [2*RT_W-1:0] sqv  [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [SUM_W:0] t;
      logic [SUM_W:0] d;
      logic           ge;
      if (k == 0) begin : g_first
        assign t = (SUM_W+1)'(sq);
        assign d = {1'b0, sum};
      end else begin : g_next
        assign t = {dr[k-1], 1'b0};
        assign d = {1'b0, ds[k-1]};
      end
      assign ge = (t >= d);
      always_ff @(posedge clk) begin
        if (en) begin
          dr[k] <= ge ? SUM_W'(t - d) : SUM_W'(t);
          ds[k] <= d[SUM_W-1:0];
          if (k == 0) dq[k] <= Q_W'(ge);
          else        dq[k] <= {dq[(k == 0) ? 0 : k-1][Q_W-2:0], ge};
        end
      end
    end

    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [2*RT_W-1:0] qv;
      logic [SR_W-1:0]   rin;
      logic [RT_W-1:0]   rtin;
      logic [SR_W+1:0]   cur;
      logic [SR_W+1:0]   trial;
      logic              ge;
      if (k == 0) begin : g_first
        assign qv   = (2*RT_W)'(dq[DIV_STEPS-1]);
        assign rin  = '0;
        assign rtin = '0;
      end else begin : g_next
        assign qv   = sqv[k-1];
        assign rin  = srem[k-1];
        assign rtin = sroot[k-1];
      end
      assign cur   = {rin, qv[2*(SQRT_STEPS-1-k)+1 -: 2]};
      assign trial = (SR_W+2)'({rtin, 2'b01});
      assign ge    = (cur >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          srem[k]  <= ge ? SR_W'(cur - trial) : SR_W'(cur);
          sroot[k] <= {rtin[RT_W-2:0], ge};
          sqv[k]   <= qv;
        end
      end
    end
  endgenerate

  assign root = sroot[SQRT_STEPS-1];
endmodule
`default_nettype wire

// File: design/vector_normalize.sv
// Four-component vector normalizer, Q1.15 unit vector out.
// Pipeline: magnitude, square and sum stages, 31 divide stages,
// 16 square-root stages, 1 output stage; one request per cycle when
// not stalled. A stall at the output holds the whole pipeline.
// Reset clears all stage valid bits. Depends on vn_pkg and vn_lane.
`default_nettype none
module vector_normalize import vn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [CW-1:0] comp_x,
  input  wire logic signed [CW-1:0] comp_y,
  input  wire logic signed [CW-1:0] comp_z,
  input  wire logic signed [CW-1:0] comp_w,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [15:0]        unit_x,
  output logic signed [15:0]        unit_y,
  output logic signed [15:0]        unit_z,
  output logic signed [15:0]        unit_w,
  output logic                      zero_vector
);
  logic            en;
  logic [NST-1:0]  vld;
  logic [CW-1:0]   comp [NC];
  logic [CW-1:0]   mag1 [NC];
  logic [SQ_W-1:0] sq2  [NC];
  logic [SQ_W-1:0] sq3  [NC];
  logic [SUM_W-1:0] sum3;
  logic [NC-1:0]   neg1, neg2, neg3;
  logic            zero3;
  logic [NC-1:0]   negd [LANE_LAT];
  logic            zerod [LANE_LAT];
  logic [RT_W-1:0] root [NC];
  logic [15:0]     unit [NC];

  assign en       = !(vld[NST-1] && out_stall);
  assign in_stall = !en;
  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;
  assign comp[3] = comp_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        neg1[i] <= comp[i][CW-1];
        mag1[i] <= comp[i][CW-1] ? CW'(-comp[i]) : comp[i];
        sq2[i]  <= SQ_W'(mag1[i]) * SQ_W'(mag1[i]);
        sq3[i]  <= sq2[i];
      end
      neg2  <= neg1;
      neg3  <= neg2;
      sum3  <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]) + SUM_W'(sq2[3]);
      zero3 <= (sq2[0] == '0) && (sq2[1] == '0) && (sq2[2] == '0) && (sq2[3] == '0);
      negd[0]  <= neg3;
      zerod[0] <= zero3;
      for (int j = 1; j < LANE_LAT; j++) begin
        negd[j]  <= negd[j-1];
        zerod[j] <= zerod[j-1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_lane
      logic [RT_W:0] clip;
      vn_lane u_lane (
        .clk  (clk),
        .en   (en),
        .sq   (sq3[g]),
        .sum  (sum3),
        .root (root[g])
      );
      // clamp to 32768 for negative, 32767 for positive
      always_comb begin
        if (negd[LANE_LAT-1][g]) begin
          clip = (root[g] > 16'd32768) ? 17'd32768 : {1'b0, root[g]};
          clip = (RT_W+1)'(~clip + 17'd1);
        end else begin
          clip = (root[g] > 16'd32767) ? 17'd32767 : {1'b0, root[g]};
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          unit[g] <= zerod[LANE_LAT-1] ? 16'd0 : clip[15:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      zero_vector <= zerod[LANE_LAT-1];
    end
  end

  assign out_valid = vld[NST-1];
  assign unit_x = unit[0];
  assign unit_y = unit[1];
  assign unit_z = unit[2];
  assign unit_w = unit[3];
endmodule
`default_nettype wire

// File: tb/vector_normalize_test.sv
// Self-checking testbench for vector_normalize: directed table, then random vectors.
// Depends on vn_pkg and the vector_normalize RTL; computes unit vectors itself.
`timescale 1ns / 1ps
module vector_normalize_test;
  import vn_pkg::*;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] uw;
    logic               zv;
  } unit_vec_t;

  typedef struct {
    logic signed [CW-1:0] c [4];
    bit                   typed;
    unit_vec_t            want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] unit_x, unit_y, unit_z, unit_w;
  logic zero_vector;

  unit_vec_t unit_queue[$];
  int errors = 0;
  bit stim_done = 1'b0;
  vec_row_t rows[$];

  vector_normalize u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
    .zero_vector(zero_vector)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // largest m below 65536 with m*m*sum <= mag*mag*2^30
  function automatic logic [16:0] scaled_mag(logic [31:0] mag, logic [63:0] sum);
    logic [127:0] target;
    logic [127:0] lhs;
    logic [16:0] m;
    logic [16:0] t;
    target = ({96'd0, mag} * mag) << 30;
    m = '0;
    for (int b = 15; b >= 0; b--) begin
      t = m | (17'd1 << b);
      lhs = {64'd0, sum} * t * t;
      if (lhs <= target) m = t;
    end
    return m;
  endfunction

  function automatic unit_vec_t normalize(logic signed [CW-1:0] c [4]);
    unit_vec_t r;
    logic [31:0] mag [4];
    logic [63:0] sum;
    logic [16:0] m;
    logic [15:0] o [4];
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = c[i] < 0 ? 32'(-32'(c[i])) : 32'(c[i]);
      sum += {32'd0, mag[i]} * mag[i];
    end
    for (int i = 0; i < 4; i++) begin
      o[i] = '0;
      if (sum != 0 && mag[i] != 0) begin
        m = scaled_mag(mag[i], sum);
        if (c[i] < 0) begin
          if (m > 17'd32768) m = 17'd32768;
          o[i] = 16'(-m);
        end else begin
          if (m > 17'd32767) m = 17'd32767;
          o[i] = m[15:0];
        end
      end
    end
    r.ux = o[0]; r.uy = o[1]; r.uz = o[2]; r.uw = o[3];
    r.zv = (sum == 0);
    return r;
  endfunction

  function automatic vec_row_t mk(int x, int y, int z, int w, bit typed = 0,
                                  unit_vec_t want = '0);
    vec_row_t r;
    r.c[0] = CW'(x); r.c[1] = CW'(y); r.c[2] = CW'(z); r.c[3] = CW'(w);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CW'($urandom_range(0, 15)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic signed [CW-1:0] c [4]);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    comp_x <= c[0]; comp_y <= c[1]; comp_z <= c[2]; comp_w <= c[3];
    in_valid <= 1'b1;
    unit_queue.push_back(normalize(c));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    vec_row_t r;
    logic signed [CW-1:0] c [4];
    int dims;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rows.push_back(mk(0, 0, 0, 0, 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}));
    // plus one saturates, minus one fits
    rows.push_back(mk(5, 0, 0, 0, 1, '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0}));
    rows.push_back(mk(0, -7, 0, 0, 1, '{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b0}));
    rows.push_back(mk(0, 0, 32767, 0, 1, '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0}));
    rows.push_back(mk(0, 0, 0, -32768, 1, '{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0}));
    rows.push_back(mk(-32768, -32768, -32768, -32768));
    rows.push_back(mk(32767, 32767, 32767, 32767));
    rows.push_back(mk(32767, -32768, 32767, -32768));
    rows.push_back(mk(3, 4, 0, 0));
    rows.push_back(mk(1, 2, 2, 0));
    rows.push_back(mk(1, 1, 1, 1));
    rows.push_back(mk(1, -32768, 0, 0));
    rows.push_back(mk(-1, 32767, 0, 1));
    rows.push_back(mk(-21846, 21845, -1, 0));
    rows.push_back(mk(12345, -6789, 1011, -1213));
    foreach (rows[i]) begin
      r = rows[i];
      send_vector(r.c);
      if (r.typed) unit_queue[$] = r.want;
    end
    for (int n = 0; n < 1150; n++) begin
      dims = $urandom_range(2, 4);
      for (int i = 0; i < 4; i++) c[i] = i < dims ? rand_comp() : '0;
      send_vector(c);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern: per result, out_stall is held high for a random hold, or not at all
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    unit_vec_t want;
    unit_vec_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{unit_x, unit_y, unit_z, unit_w, zero_vector};
      if (unit_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = unit_queue.pop_front();
        if (got.ux !== want.ux)
          $display("%0t: unit_x expected %0d actual %0d", $time, want.ux, got.ux);
        if (got.uy !== want.uy)
          $display("%0t: unit_y expected %0d actual %0d", $time, want.uy, got.uy);
        if (got.uz !== want.uz)
          $display("%0t: unit_z expected %0d actual %0d", $time, want.uz, got.uz);
        if (got.uw !== want.uw)
          $display("%0t: unit_w expected %0d actual %0d", $time, want.uw, got.uw);
        if (got.zv !== want.zv)
          $display("%0t: zero_vector expected %0b actual %0b", $time, want.zv, got.zv);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (unit_queue.size() == 0);
    repeat (NST + 20) @(posedge clk);
    if (errors == 0 && unit_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: filelist.f
design/vn_pkg.sv
design/vn_lane.sv
design/vector_normalize.sv
tb/vector_normalize_test.sv
